FILE: sv/sha1md_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types and constants shared by the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 3;
    localparam int SLOT_W  = 4;
    localparam int POS_W   = 6;
    localparam int ROUND_W = 7;
    localparam int BCNT_W  = 61;

    localparam logic [WORD_W-1:0] H_INIT [0:4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_ROUND_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_ROUND_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_ROUND_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_ROUND_3 = 32'hCA62C1D6;

    localparam logic [ROUND_W-1:0] ROUND_LAST    = 7'd79;
    localparam logic [ROUND_W-1:0] ROUND_SCHED   = 7'd16;
    localparam logic [ROUND_W-1:0] ROUND_PHASE_1 = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_PHASE_2 = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_PHASE_3 = 7'd60;

    localparam logic [BYTE_W-1:0]  PAD_MARK  = 8'h80;
    localparam logic [POS_W-1:0]   LEN_POS   = 6'd56;
    localparam logic [POS_W-1:0]   POS_LAST  = 6'd63;
    localparam logic [INDEX_W-1:0] WORD_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

endpackage

FILE: sv/sha1_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest
// Byte-serial SHA-1 engine with padding and a five-word digest stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one message byte per request in s_tdata, s_tlast on the final
//   byte. m_ channel: five digest words, H0 first, m_tuser the word index,
//   m_tlast on the fifth word.
//   Ordinary bytes are taken one per cycle while s_tready is high. Each
//   64-byte block is then compressed in ST_LOAD (prime the schedule memory),
//   ST_ROUND (one round per cycle for 80 rounds) and ST_FINAL (the chaining
//   add): the round loop sets the rate. After the final byte, padding is
//   generated one byte per cycle outside compressions (up to 72 bytes), with
//   an idle step before the length bytes and one or two further compressions,
//   then the five words follow, one per cycle while m_tready is high.
//   The schedule lives in a pair of mirrored 16x32 memories, each read at two
//   addresses per cycle with registered data.
//   Reset (aresetn low at a clock edge) loads the initial chaining words and
//   clears the byte position and length; the memories need no clearing.
//   s_tready is low during padding, while a block compresses and while digest
//   words wait; a stalled receiver holds the current word, and the next message
//   starts once the fifth word is taken.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sha1md_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sha1md_pkg::WORD_W-1:0]   m_tdata,   // [31:0] digest_word
    output logic [sha1md_pkg::INDEX_W-1:0]  m_tuser,   // [2:0] word_index
    output logic                            m_tlast
);
    import sha1md_pkg::*;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [BCNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   hash_reg [0:4];
    logic [WORD_W-1:0]   hash_next [0:4];
    logic [WORD_W-1:0]   wk_reg [0:4];
    logic [WORD_W-1:0]   wk_next [0:4];
    logic                m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]   m_word_reg, m_word_next;
    logic [INDEX_W-1:0]  m_idx_reg, m_idx_next;

    logic [WORD_W-1:0]   buf_a [0:15];
    logic [WORD_W-1:0]   buf_b [0:15];
    logic [WORD_W-1:0]   rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;
    logic [SLOT_W-1:0]   ra0, ra1, rb0, rb1;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic                put_en;
    logic [BYTE_W-1:0]   put_byte;
    logic [63:0]         bit_len;
    logic [WORD_W-1:0]   sched_w, round_w, round_f, round_k, round_t;
    logic [SLOT_W-1:0]   next_slot;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg;
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = (m_idx_reg == WORD_LAST);
    assign bit_len  = {bcnt_reg, 3'b000};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            pos_reg     <= '0;
            bcnt_reg    <= '0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_idx_reg   <= '0;
            for (int i = 0; i < 5; i++) begin
                hash_reg[i] <= H_INIT[i];
            end
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pos_reg     <= pos_next;
            bcnt_reg    <= bcnt_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
            m_idx_reg   <= m_idx_next;
            for (int i = 0; i < 5; i++) begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        m_word_reg <= m_word_next;
        for (int i = 0; i < 5; i++) begin
            wk_reg[i] <= wk_next[i];
        end
    end

    // schedule memories: mirrored contents, two registered reads each
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            buf_a[mem_waddr] <= mem_wdata;
            buf_b[mem_waddr] <= mem_wdata;
        end
        rd_a0_reg <= buf_a[ra0];
        rd_a1_reg <= buf_a[ra1];
        rd_b0_reg <= buf_b[rb0];
        rd_b1_reg <= buf_b[rb1];
    end

    always_comb begin
        sched_w = rd_b1_reg ^ rd_b0_reg ^ rd_a1_reg ^ rd_a0_reg;
        round_w = (round_reg < ROUND_SCHED) ? rd_a0_reg : {sched_w[30:0], sched_w[31]};
        if (round_reg < ROUND_PHASE_1) begin
            round_f = (wk_reg[1] & wk_reg[2]) | (~wk_reg[1] & wk_reg[3]);
            round_k = K_ROUND_0;
        end else if (round_reg < ROUND_PHASE_2) begin
            round_f = wk_reg[1] ^ wk_reg[2] ^ wk_reg[3];
            round_k = K_ROUND_1;
        end else if (round_reg < ROUND_PHASE_3) begin
            round_f = (wk_reg[1] & wk_reg[2]) | (wk_reg[1] & wk_reg[3])
                    | (wk_reg[2] & wk_reg[3]);
            round_k = K_ROUND_2;
        end else begin
            round_f = wk_reg[1] ^ wk_reg[2] ^ wk_reg[3];
            round_k = K_ROUND_3;
        end
        round_t = {wk_reg[0][26:0], wk_reg[0][31:27]} + round_f + wk_reg[4]
                + round_w + round_k;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        pos_next     = pos_reg;
        bcnt_next    = bcnt_reg;
        round_next   = round_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        m_idx_next   = m_idx_reg;
        for (int i = 0; i < 5; i++) begin
            hash_next[i] = hash_reg[i];
            wk_next[i]   = wk_reg[i];
        end
        put_en    = 1'b0;
        put_byte  = '0;
        mem_we    = 1'b0;
        mem_waddr = pos_reg[5:2];
        mem_wdata = {acc_reg[23:0], put_byte};
        next_slot = (state_reg == ST_ROUND) ? (round_reg[3:0] + 4'd1) : '0;
        ra0       = next_slot;
        ra1       = next_slot + 4'd2;
        rb0       = next_slot + 4'd8;
        rb1       = next_slot + 4'd13;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    put_en     = 1'b1;
                    put_byte   = s_tdata;
                    bcnt_next  = bcnt_reg + 61'd1;
                    state_next = s_tlast ? ST_PAD_MARK : ST_IDLE;
                    ret_next   = s_tlast ? ST_PAD_MARK : ST_IDLE;
                end
            end
            ST_PAD_MARK: begin
                put_en     = 1'b1;
                put_byte   = PAD_MARK;
                state_next = ST_PAD_ZERO;
                ret_next   = ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (pos_reg == LEN_POS) begin
                    state_next = ST_PAD_LEN;
                end else begin
                    put_en   = 1'b1;
                    put_byte = '0;
                    ret_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN: begin
                put_en   = 1'b1;
                put_byte = bit_len[{3'd7 - pos_reg[2:0], 3'b000} +: 8];
                ret_next = ST_OUT;
            end
            ST_LOAD: begin
                for (int i = 0; i < 5; i++) begin
                    wk_next[i] = hash_reg[i];
                end
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                wk_next[4] = wk_reg[3];
                wk_next[3] = wk_reg[2];
                wk_next[2] = {wk_reg[1][1:0], wk_reg[1][31:2]};
                wk_next[1] = wk_reg[0];
                wk_next[0] = round_t;
                if (round_reg >= ROUND_SCHED) begin
                    mem_we    = 1'b1;
                    mem_waddr = round_reg[3:0];
                    mem_wdata = round_w;
                end
                if (round_reg == ROUND_LAST) begin
                    round_next = '0;
                    state_next = ST_FINAL;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 5; i++) begin
                    hash_next[i] = hash_reg[i] + wk_reg[i];
                end
                state_next = ret_reg;
                if (ret_reg == ST_OUT) begin
                    m_valid_next = 1'b1;
                    m_word_next  = hash_reg[0] + wk_reg[0];
                    m_idx_next   = '0;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (m_idx_reg == WORD_LAST) begin
                        m_valid_next = 1'b0;
                        m_idx_next   = '0;
                        pos_next     = '0;
                        bcnt_next    = '0;
                        state_next   = ST_IDLE;
                        ret_next     = ST_IDLE;
                        for (int i = 0; i < 5; i++) begin
                            hash_next[i] = H_INIT[i];
                        end
                    end else begin
                        m_idx_next  = m_idx_reg + 3'd1;
                        m_word_next = hash_reg[m_idx_reg + 3'd1];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // pack each request or padding byte big-endian; a full block starts compression
        if (put_en) begin
            acc_next  = {acc_reg[23:0], put_byte};
            pos_next  = pos_reg + 6'd1;
            mem_wdata = {acc_reg[23:0], put_byte};
            mem_waddr = pos_reg[5:2];
            mem_we    = (pos_reg[1:0] == 2'b11);
            if (pos_reg == POS_LAST) begin
                state_next = ST_LOAD;
            end
        end
    end

`ifndef SYNTHESIS
    a_out_only_in_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == ST_OUT))
        else $error("digest word presented outside output phase");

    a_no_input_while_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request accepted while digest words pending");

    a_round_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ROUND) |-> (round_reg == '0))
        else $error("round counter not cleared outside compression");

    a_restart_after_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=>
            (pos_reg == '0 && bcnt_reg == '0 && s_tready && !m_tvalid))
        else $error("engine not restarted after final digest word");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream check of the SHA-1 message digest block.
// Messages of one byte up to a few blocks, with extra weight on lengths near
// the padding boundaries, are sent with random gaps on most messages. A
// software SHA-1 kept in a scoreboard predicts the five digest words of every
// message, which are compared in order as the receiver takes them.
// ----------------------------------------------------------------------------
module testbench;

    import sha1md_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               last;
    } digest_word_t;

    class digest_scoreboard;
        logic [WORD_W-1:0] chain [5];
        logic [WORD_W-1:0] block_words [16];
        logic [POS_W-1:0]  fill_pos;
        logic [63:0]       bit_length;
        digest_word_t      expected [$];
        int                failures;
        int                bytes_taken;
        int                messages_done;
        int                words_checked;

        function new();
            foreach (block_words[i]) block_words[i] = '0;
            restart();
            failures      = 0;
            bytes_taken   = 0;
            messages_done = 0;
            words_checked = 0;
        endfunction

        function void restart();
            foreach (chain[i]) chain[i] = H_INIT[i];
            fill_pos   = '0;
            bit_length = '0;
        endfunction

        function logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
            return (x << n) | (x >> (WORD_W - n));
        endfunction

        function void compress();
            logic [WORD_W-1:0] a, b, c, d, e, f, k, t, w;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r < 16) begin
                    w = block_words[r];
                end else begin
                    w = rotl(block_words[(r + 13) & 15] ^ block_words[(r + 8) & 15] ^
                             block_words[(r + 2) & 15] ^ block_words[r & 15], 1);
                    block_words[r & 15] = w;
                end
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = K_ROUND_0;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = K_ROUND_1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_ROUND_2;
                end else begin
                    f = b ^ c ^ d;
                    k = K_ROUND_3;
                end
                t = rotl(a, 5) + f + e + w + k;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void absorb(input logic [BYTE_W-1:0] data);
            int idx;
            int shift;
            idx   = fill_pos[5:2];
            shift = 8 * (3 - fill_pos[1:0]);
            if (fill_pos[1:0] == 2'd0) block_words[idx] = '0;
            block_words[idx] |= WORD_W'(data) << shift;
            fill_pos = fill_pos + 1'b1;
            if (fill_pos == '0) compress();
        endfunction

        function void note_request(input logic [BYTE_W-1:0] data, input logic last);
            logic [63:0]  length;
            digest_word_t item;
            absorb(data);
            bit_length += 64'd8;
            bytes_taken++;
            if (!last) return;
            length = bit_length;
            absorb(PAD_MARK);
            while (fill_pos != LEN_POS) absorb(8'h00);
            for (int i = 7; i >= 0; i--) absorb(length[8*i +: 8]);
            for (int i = 0; i < 5; i++) begin
                item.word  = chain[i];
                item.index = INDEX_W'(i);
                item.last  = (INDEX_W'(i) == WORD_LAST);
                expected.push_back(item);
            end
            messages_done++;
            restart();
        endfunction

        function void check_word(input logic [WORD_W-1:0] word,
                                 input logic [INDEX_W-1:0] index, input logic last);
            digest_word_t want;
            if (expected.size() == 0) begin
                $error("digest_word: no word expected, actual %08h", word);
                failures++;
                return;
            end
            want = expected.pop_front();
            words_checked++;
            if (word !== want.word) begin
                $error("digest_word: expected %08h, actual %08h", want.word, word);
                failures++;
            end
            if (index !== want.index) begin
                $error("word_index: expected %0d, actual %0d", want.index, index);
                failures++;
            end
            if (last !== want.last) begin
                $error("last_word: expected %0b, actual %0b", want.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [WORD_W-1:0]  m_tdata;
    logic [INDEX_W-1:0] m_tuser;
    logic               m_tlast;

    digest_scoreboard sb = new();
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int hold_cycles = 0;

    sha1_message_digest dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver: random stalls, a counted hold-off, or always ready
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_gaps) begin
                m_tready <= ($urandom_range(0, 99) >= 15);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
        while (tx_gaps && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(data, last);
        @(negedge aclk);
    endtask

    task automatic send_message(input logic [BYTE_W-1:0] msg [$]);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++) send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic int pick_length();
        int r;
        int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 12);
        if (r < 85) return edges[$urandom_range(0, 7)];
        return $urandom_range(13, 140);
    endfunction

    initial begin
        int n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'h61, 8'h62, 8'h63});
        send_message('{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01});
        send_message('{8'hAA, 8'h55, 8'h0F, 8'hF0, 8'hFE, 8'h01, 8'hFF, 8'h00});

        n = 0;
        while (sb.bytes_taken < 500) begin
            tx_gaps = !(n >= 8 && n < 16);
            rx_gaps = tx_gaps;
            if (n == 3) hold_cycles = 300;
            send_random_message(pick_length());
            if (n == 6) wait_drained();
            n++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Covered %0d messages, %0d bytes; %0d digest words checked.",
                 sb.messages_done, sb.bytes_taken, sb.words_checked);
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sha1md_pkg.sv
sv/sha1_message_digest.sv
tb/testbench.sv
